/* rtl/core/thermistor_temperature_converter_defines.svh */
// Assertion macros shared by the converter RTL.
`ifndef THERMISTOR_TEMPERATURE_CONVERTER_DEFINES_SVH
`define THERMISTOR_TEMPERATURE_CONVERTER_DEFINES_SVH

// Same-cycle implication.
`define TTC_ASSERT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("converter assertion failed");

// Next-cycle implication.
`define TTC_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("converter assertion failed");

`endif

/* rtl/core/ttc_pkg.sv */
package ttc_pkg;

  localparam int unsigned ADC_MAX     = 4095;
  localparam int unsigned MAX_SAMPLES = 255;

  localparam int SAMPLE_W   = 12;
  localparam int SUM_W      = 20;
  localparam int CNT_W      = 8;
  localparam int OHM_W      = 20;
  localparam int MV_W       = 13;
  localparam int BETA_W     = 14;
  localparam int TEMPC_W    = 9;
  localparam int IDX_W      = 4;
  localparam int CFG_DATA_W = 20;
  localparam int DIV_W      = 64;

  localparam logic [IDX_W-1:0] CFG_SAMPLES = 4'd0;
  localparam logic [IDX_W-1:0] CFG_SERIES  = 4'd1;
  localparam logic [IDX_W-1:0] CFG_NOMINAL = 4'd2;
  localparam logic [IDX_W-1:0] CFG_TEMP_C  = 4'd3;
  localparam logic [IDX_W-1:0] CFG_BETA    = 4'd4;
  localparam logic [IDX_W-1:0] CFG_TFIRST  = 4'd5;
  localparam logic [IDX_W-1:0] CFG_VCC     = 4'd6;
  localparam logic [IDX_W-1:0] CFG_AREF    = 4'd7;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_INVALID  = 2'd1;
  localparam logic [1:0] STATUS_RES_SAT  = 2'd2;
  localparam logic [1:0] STATUS_TEMP_SAT = 2'd3;

  localparam logic [DIV_W-1:0] RES_TOP  = 64'd16777215;
  localparam logic [DIV_W-1:0] VOLT_TOP = 64'd8388607;
  localparam logic [DIV_W-1:0] TEMP_TOP = 64'd100000;
  localparam logic [31:0]      LN2_Q24  = 32'd11629080;
  // 100 * 2^41: twice the centi-kelvin numerator in Q.40
  localparam logic [DIV_W-1:0] K_Q41    = 64'd100 << 41;
  // ceil(2^23 / 5); exact floor division by 5 for operands below 2^22
  localparam logic [31:0]      FIFTH_Q23 = 32'd1677722;

  localparam int ABS_ZERO_CENTI = 27315;
  localparam int F_OFFSET       = 45967;

  typedef struct packed {
    logic [CNT_W-1:0]   samples;
    logic [OHM_W-1:0]   series;
    logic [OHM_W-1:0]   nominal;
    logic [TEMPC_W-1:0] temp_c;
    logic [BETA_W-1:0]  beta;
    logic               therm_first;
    logic [MV_W-1:0]    vcc;
    logic [MV_W-1:0]    aref;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } reading_t;

endpackage

/* rtl/core/ttc_front.sv */
module ttc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ttc_pkg::CNT_W-1:0]   samples,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ttc_pkg::SAMPLE_W-1:0] adc_sample,
  input  logic                        q_full,
  output logic                        push,
  output ttc_pkg::reading_t           push_data
);
  import ttc_pkg::*;

  logic [SUM_W-1:0] sample_sum, sum_next;
  logic [CNT_W-1:0] sample_counter, count_next, n_eff;
  logic             accept, reading_done;

  always_comb begin
    if (samples == '0) begin
      n_eff = CNT_W'(1);
    end else if (samples > CNT_W'(MAX_SAMPLES)) begin
      n_eff = CNT_W'(MAX_SAMPLES);
    end else begin
      n_eff = samples;
    end
  end

  assign in_stall     = q_full;
  assign accept       = in_valid && !q_full;
  assign sum_next     = sample_sum + SUM_W'(adc_sample);
  assign count_next   = sample_counter + CNT_W'(1);
  assign reading_done = count_next >= n_eff;
  assign push         = accept && reading_done;
  assign push_data    = '{sum: sum_next, count: n_eff};

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum     <= '0;
      sample_counter <= '0;
    end else if (accept) begin
      if (reading_done) begin
        sample_sum     <= '0;
        sample_counter <= '0;
      end else begin
        sample_sum     <= sum_next;
        sample_counter <= count_next;
      end
    end
  end

endmodule

/* rtl/core/ttc_queue.sv */
`include "thermistor_temperature_converter_defines.svh"

module ttc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ttc_pkg::reading_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              avail,
  output ttc_pkg::reading_t pop_data
);
  import ttc_pkg::*;

  reading_t   entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full     = count == 2'd2;
  assign avail    = count != 2'd0;
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  `TTC_ASSERT(q_no_push_when_full, clk, rst, full, !push)
  `TTC_ASSERT(q_no_pop_when_empty, clk, rst, !avail, !pop)

endmodule

/* rtl/core/ttc_divider.sv */
`include "thermistor_temperature_converter_defines.svh"

module ttc_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ttc_pkg::DIV_W-1:0] dividend,
  input  logic [ttc_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output logic [ttc_pkg::DIV_W-1:0] quotient
);
  import ttc_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W-1:0] rem, work, dsr;
  logic [DIV_W:0]   trial;
  logic             ge, busy;
  logic [CW-1:0]    cnt;

  // restoring, one quotient bit per cycle
  assign trial    = {rem, work[DIV_W-1]};
  assign ge       = trial >= {1'b0, dsr};
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        work <= dividend;
        dsr  <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? DIV_W'(trial - {1'b0, dsr}) : trial[DIV_W-1:0];
        work <= {work[DIV_W-2:0], ge};
        cnt  <= cnt + CW'(1);
        if (cnt == CW'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  `TTC_ASSERT(dv_no_start_busy, clk, rst, start, !busy)

endmodule

/* rtl/core/ttc_back.sv */
`include "thermistor_temperature_converter_defines.svh"

module ttc_back (
  input  logic                clk,
  input  logic                rst,
  input  ttc_pkg::cfg_t       cfg,
  input  logic                avail,
  input  ttc_pkg::reading_t   pop_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [19:0]         avg_counts_q8,
  output logic [22:0]         voltage_uv,
  output logic [23:0]         resistance_ohms,
  output logic [16:0]         temp_centi_k,
  output logic signed [17:0]  temp_centi_c,
  output logic signed [18:0]  temp_centi_f,
  output logic [1:0]          status
);
  import ttc_pkg::*;

  typedef enum logic [32:0] {
    S_IDLE   = 33'd1 << 0,  S_PREP   = 33'd1 << 1,  S_AVG    = 33'd1 << 2,
    S_VMUL   = 33'd1 << 3,  S_VDIV   = 33'd1 << 4,  S_VWAIT  = 33'd1 << 5,
    S_R0     = 33'd1 << 6,  S_R1     = 33'd1 << 7,  S_R2     = 33'd1 << 8,
    S_R3     = 33'd1 << 9,  S_R4     = 33'd1 << 10, S_R5     = 33'd1 << 11,
    S_RDIV   = 33'd1 << 12, S_RWAIT  = 33'd1 << 13, S_BCHK   = 33'd1 << 14,
    S_LNORM  = 33'd1 << 15, S_LSQ    = 33'd1 << 16, S_LSQ2   = 33'd1 << 17,
    S_DN0    = 33'd1 << 18, S_DN1    = 33'd1 << 19, S_DN2    = 33'd1 << 20,
    S_DIFF   = 33'd1 << 21, S_LN0    = 33'd1 << 22, S_LN1    = 33'd1 << 23,
    S_LN2    = 33'd1 << 24, S_QWAIT  = 33'd1 << 25, S_T0     = 33'd1 << 26,
    S_T0WAIT = 33'd1 << 27, S_SCMP   = 33'd1 << 28, S_CKWAIT = 33'd1 << 29,
    S_CF     = 33'd1 << 30, S_CFWAIT = 33'd1 << 31, S_OUT    = 33'd1 << 32
  } state_t;

  state_t state;

  logic [SUM_W-1:0] sum, full;
  logic [CNT_W-1:0] n;
  logic [22:0]      k1000, volt;
  logic [19:0]      avg;
  logic [32:0]      top, sub, as;
  logic [53:0]      num;
  logic [33:0]      den;
  logic             ok, neg, second;
  logic [63:0]      x, tmp;
  logic [5:0]       e;
  logic [31:0]      y;
  logic [29:0]      f;
  logic [4:0]       it;
  logic [35:0]      la, lb, dmag;
  logic [47:0]      q;
  logic [39:0]      inv0;
  logic [23:0]      res;
  logic [16:0]      ck;
  logic signed [17:0] cc;
  logic signed [18:0] cf;
  logic [1:0]       st;

  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_p;
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_dividend, div_divisor, div_quot;

  logic signed [16:0] t0;
  logic [63:0]      s_u, ln_sum;
  logic             s_pos, sq_bit;
  logic [29:0]      f_new;
  logic             temps_zero;

  ttc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign t0     = 17'($signed(cfg.temp_c)) * 17'sd100 + 17'sd27315;
  assign s_u    = neg ? 64'(inv0) - 64'(q) : 64'(inv0) + 64'(q);
  assign s_pos  = !s_u[63] && (s_u != '0);
  assign ln_sum = tmp + {mul_p[31:0], 32'b0};
  assign sq_bit = mul_p[63];
  assign f_new  = {f[28:0], sq_bit};

  // shared 32x32 multiplier, product registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_VMUL: begin
        mul_a = 32'(k1000);
        mul_b = 32'(sum);
      end
      S_R0: begin
        if (cfg.therm_first) begin
          mul_a = 32'(cfg.series);
          mul_b = 32'(full - sum);
        end else begin
          mul_a = 32'(cfg.vcc);
          mul_b = 32'(full);
        end
      end
      S_R1: begin
        mul_a = 32'(cfg.aref);
        mul_b = 32'(sum);
      end
      S_R2: begin
        mul_a = 32'(cfg.aref);
        mul_b = 32'(cfg.series);
      end
      S_R4: begin
        mul_a = as[31:0];
        mul_b = 32'(sum);
      end
      S_LSQ: begin
        mul_a = y;
        mul_b = y;
      end
      S_DN0: begin
        mul_a = den[31:0];
        mul_b = 32'(cfg.nominal);
      end
      S_DN1: begin
        mul_a = 32'(den[33:32]);
        mul_b = 32'(cfg.nominal);
      end
      S_LN0: begin
        mul_a = dmag[31:0];
        mul_b = LN2_Q24;
      end
      S_LN1: begin
        mul_a = 32'(dmag[35:32]);
        mul_b = LN2_Q24;
      end
      // (9k + 2) / 5 by reciprocal multiplication
      S_CF: begin
        mul_a = 32'({ck, 3'b0}) + 32'(ck) + 32'd2;
        mul_b = FIFTH_Q23;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // divider launch; rounded quotients use (2a + b) / (2b)
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state)
      S_PREP: begin
        div_start    = 1'b1;
        div_dividend = 64'({sum, 9'b0}) + 64'(n);
        div_divisor  = 64'({n, 1'b0});
      end
      S_VDIV: begin
        div_start    = 1'b1;
        div_dividend = {mul_p[62:0], 1'b0} + 64'(full);
        div_divisor  = 64'({full, 1'b0});
      end
      S_RDIV: begin
        div_start    = ok;
        div_dividend = 64'({num, 1'b0}) + 64'(den);
        div_divisor  = 64'({den, 1'b0});
      end
      S_LN2: begin
        div_start    = 1'b1;
        div_dividend = 64'({ln_sum[63:24], 10'b0});
        div_divisor  = 64'(cfg.beta);
      end
      S_T0: begin
        div_start    = 1'b1;
        div_dividend = K_Q41 + 64'(t0[15:0]);
        div_divisor  = 64'({t0[15:0], 1'b0});
      end
      S_SCMP: begin
        div_start    = s_pos;
        div_dividend = K_Q41 + s_u;
        div_divisor  = {s_u[62:0], 1'b0};
      end
      default: begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  assign pop = (state == S_IDLE) && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (avail) begin
            sum   <= pop_data.sum;
            n     <= pop_data.count;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          full  <= SUM_W'(n * ADC_MAX);
          k1000 <= 23'(cfg.aref * 1000);
          state <= S_AVG;
        end
        S_AVG: begin
          if (div_done) begin
            avg   <= div_quot[19:0];
            state <= S_VMUL;
          end
        end
        S_VMUL: state <= S_VDIV;
        S_VDIV: state <= S_VWAIT;
        S_VWAIT: begin
          if (div_done) begin
            volt  <= (div_quot > VOLT_TOP) ? 23'h7FFFFF : div_quot[22:0];
            state <= S_R0;
          end
        end
        S_R0: begin
          ok <= (cfg.aref != '0) && (sum != '0) && (full > sum) && (cfg.series != '0);
          state <= S_R1;
        end
        S_R1: begin
          if (cfg.therm_first) begin
            num   <= mul_p[53:0];
            den   <= 34'(sum);
            state <= S_RDIV;
          end else begin
            top   <= mul_p[32:0];
            state <= S_R2;
          end
        end
        S_R2: begin
          sub   <= mul_p[32:0];
          state <= S_R3;
        end
        S_R3: begin
          as    <= mul_p[32:0];
          ok    <= (top > sub) && (sub != '0) && (cfg.series != '0);
          den   <= {1'b0, top - sub};
          state <= S_R4;
        end
        S_R4: state <= S_R5;
        S_R5: begin
          num   <= mul_p[53:0] + (as[32] ? {2'b0, sum, 32'b0} : 54'd0);
          state <= S_RDIV;
        end
        S_RDIV: begin
          if (!ok) begin
            st    <= STATUS_INVALID;
            res   <= '0;
            ck    <= '0;
            cc    <= '0;
            cf    <= '0;
            state <= S_OUT;
          end else begin
            state <= S_RWAIT;
          end
        end
        S_RWAIT: begin
          if (div_done) begin
            if (div_quot > RES_TOP) begin
              res <= 24'hFFFFFF;
              num <= 54'(RES_TOP);
              den <= 34'd1;
              st  <= STATUS_RES_SAT;
            end else begin
              res <= div_quot[23:0];
              st  <= STATUS_OK;
            end
            state <= S_BCHK;
          end
        end
        S_BCHK: begin
          if (cfg.beta == '0 || cfg.nominal == '0) begin
            st    <= STATUS_INVALID;
            ck    <= '0;
            cc    <= '0;
            cf    <= '0;
            state <= S_OUT;
          end else begin
            x      <= 64'(num);
            e      <= 6'd63;
            second <= 1'b0;
            state  <= S_LNORM;
          end
        end
        // log2: normalise, then refine the mantissa by repeated squaring
        S_LNORM: begin
          if (x[63]) begin
            y     <= x[63:32];
            f     <= '0;
            it    <= '0;
            state <= S_LSQ;
          end else if (x[63:56] == 8'd0) begin
            x <= {x[55:0], 8'b0};
            e <= e - 6'd8;
          end else begin
            x <= {x[62:0], 1'b0};
            e <= e - 6'd1;
          end
        end
        S_LSQ: state <= S_LSQ2;
        S_LSQ2: begin
          y  <= sq_bit ? mul_p[63:32] : mul_p[62:31];
          f  <= f_new;
          it <= it + 5'd1;
          if (it == 5'd29) begin
            if (second) begin
              lb    <= {e, f_new};
              state <= S_DIFF;
            end else begin
              la    <= {e, f_new};
              state <= S_DN0;
            end
          end else begin
            state <= S_LSQ;
          end
        end
        S_DN0: state <= S_DN1;
        S_DN1: begin
          tmp   <= mul_p;
          state <= S_DN2;
        end
        S_DN2: begin
          x      <= tmp + {mul_p[31:0], 32'b0};
          e      <= 6'd63;
          second <= 1'b1;
          state  <= S_LNORM;
        end
        S_DIFF: begin
          neg   <= lb > la;
          dmag  <= (lb > la) ? lb - la : la - lb;
          state <= S_LN0;
        end
        S_LN0: state <= S_LN1;
        S_LN1: begin
          tmp   <= mul_p;
          state <= S_LN2;
        end
        S_LN2: state <= S_QWAIT;
        S_QWAIT: begin
          if (div_done) begin
            q     <= div_quot[47:0];
            state <= S_T0;
          end
        end
        S_T0: state <= S_T0WAIT;
        S_T0WAIT: begin
          if (div_done) begin
            inv0  <= div_quot[39:0];
            state <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (!s_pos) begin
            st    <= STATUS_INVALID;
            ck    <= '0;
            cc    <= '0;
            cf    <= '0;
            state <= S_OUT;
          end else begin
            state <= S_CKWAIT;
          end
        end
        S_CKWAIT: begin
          if (div_done) begin
            if (div_quot > TEMP_TOP) begin
              ck <= 17'(TEMP_TOP);
              if (st == STATUS_OK) begin
                st <= STATUS_TEMP_SAT;
              end
            end else begin
              ck <= div_quot[16:0];
            end
            state <= S_CF;
          end
        end
        S_CF: begin
          cc    <= $signed({1'b0, ck}) - 18'(ABS_ZERO_CENTI);
          state <= S_CFWAIT;
        end
        S_CFWAIT: begin
          cf    <= 19'(mul_p[40:23]) - 19'(F_OFFSET);
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = state == S_OUT;
  assign avg_counts_q8   = avg;
  assign voltage_uv      = volt;
  assign resistance_ohms = res;
  assign temp_centi_k    = ck;
  assign temp_centi_c    = cc;
  assign temp_centi_f    = cf;
  assign status          = st;
  assign temps_zero      = (ck == '0) && (cc == '0) && (cf == '0);

  `TTC_ASSERT(bk_invalid_zero, clk, rst, out_valid && status == STATUS_INVALID, temps_zero)
  `TTC_ASSERT(bk_temp_range, clk, rst, out_valid, temp_centi_k <= 17'd100000)
  `TTC_ASSERT_NEXT(bk_single_beat, clk, rst, out_valid && !out_stall, !out_valid)

endmodule

/* rtl/core/thermistor_temperature_converter.sv */
// Channel  | Signals                                   | Beat on
// ---------+-------------------------------------------+--------------------------
// samples  | in_valid, in_stall, adc_sample            | in_valid & !in_stall
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid & cfg_ready
// readings | out_valid, out_stall, result fields       | out_valid & !out_stall
//
// Each sample beat adds to a running sum; the beat that completes the samples
// count queues a reading. A full reading in the back end runs six divisions
// through the one shared divider and two log2 passes of 30 squarings each; a
// rejected divider ends the reading before the log2 passes. Reset (rst,
// synchronous) clears the running sum, the queue and the sequencer and loads
// the register defaults. in_stall rises only while the two-entry queue is
// full; a stalled result holds in its output register.
`include "thermistor_temperature_converter_defines.svh"

module thermistor_temperature_converter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ttc_pkg::SAMPLE_W-1:0]    adc_sample,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ttc_pkg::IDX_W-1:0]       cfg_index,
  input  logic [ttc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [19:0]                     avg_counts_q8,
  output logic [22:0]                     voltage_uv,
  output logic [23:0]                     resistance_ohms,
  output logic [16:0]                     temp_centi_k,
  output logic signed [17:0]              temp_centi_c,
  output logic signed [18:0]              temp_centi_f,
  output logic [1:0]                      status
);
  import ttc_pkg::*;

  cfg_t     cfg;
  logic     q_full, q_push, q_pop, q_avail;
  reading_t q_in, q_out;

  // register file; writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.samples     <= 8'd10;
      cfg.series      <= 20'd10000;
      cfg.nominal     <= 20'd10000;
      cfg.temp_c      <= 9'd25;
      cfg.beta        <= 14'd3950;
      cfg.therm_first <= 1'b0;
      cfg.vcc         <= 13'd3300;
      cfg.aref        <= 13'd3300;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SAMPLES: cfg.samples     <= cfg_data[CNT_W-1:0];
        CFG_SERIES:  cfg.series      <= cfg_data[OHM_W-1:0];
        CFG_NOMINAL: cfg.nominal     <= cfg_data[OHM_W-1:0];
        CFG_TEMP_C:  cfg.temp_c      <= cfg_data[TEMPC_W-1:0];
        CFG_BETA:    cfg.beta        <= cfg_data[BETA_W-1:0];
        CFG_TFIRST:  cfg.therm_first <= cfg_data[0];
        CFG_VCC:     cfg.vcc         <= cfg_data[MV_W-1:0];
        CFG_AREF:    cfg.aref        <= cfg_data[MV_W-1:0];
        default:     cfg.samples     <= cfg.samples;
      endcase
    end
  end

  // front end: running sum and count
  ttc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (cfg.samples),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .adc_sample (adc_sample),
    .q_full     (q_full),
    .push       (q_push),
    .push_data  (q_in)
  );

  // decouples the sample side from the slow maths
  ttc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_data  (q_out)
  );

  // back end: averages, divider resistance, Beta equation
  ttc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .avail           (q_avail),
    .pop_data        (q_out),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .avg_counts_q8   (avg_counts_q8),
    .voltage_uv      (voltage_uv),
    .resistance_ohms (resistance_ohms),
    .temp_centi_k    (temp_centi_k),
    .temp_centi_c    (temp_centi_c),
    .temp_centi_f    (temp_centi_f),
    .status          (status)
  );

endmodule

/* sim/thermistor_temperature_converter_tb.sv */
module thermistor_temperature_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ttc_pkg::*;

  // Wait after the last reading before touching registers, so that a
  // part-summed reading cannot still be in flight.
  localparam int BACKEND_CYCLES = 700;
  localparam int LONG_HOLD      = 3000;
  // index past the register file; the block must ignore it
  localparam logic [IDX_W-1:0] CFG_SPARE = 4'd8;

  typedef struct packed {
    logic [19:0] avg;
    logic [22:0] volt;
    logic [23:0] res;
    logic [16:0] ck;
    logic [17:0] cc;
    logic [18:0] cf;
    logic [1:0]  st;
  } tb_reading_t;

  typedef enum logic [1:0] {ROW_REG, ROW_SAMPLE, ROW_SAMPLE_FIXED} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [IDX_W-1:0]  idx;
    logic [19:0]       data;
    tb_reading_t       reading;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [SAMPLE_W-1:0] adc_sample = '0;
  logic cfg_valid = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic out_stall = 1'b0;
  logic in_stall, cfg_ready, out_valid;
  logic [19:0] avg_counts_q8;
  logic [22:0] voltage_uv;
  logic [23:0] resistance_ohms;
  logic [16:0] temp_centi_k;
  logic signed [17:0] temp_centi_c;
  logic signed [18:0] temp_centi_f;
  logic [1:0] status;

  thermistor_temperature_converter dut (.*);

  always #5 clk = ~clk;

  // shadow of the register file and the running accumulator
  cfg_t                regs;
  logic [SUM_W-1:0]    acc_sum;
  logic [CNT_W-1:0]    acc_count;
  tb_reading_t         pending_readings[$];
  int                  mismatches = 0;
  bit                  quiet = 0;      // no idling on either side
  bit                  hold_req = 0;   // ask the receiver for a long hold-off
  stim_row_t           stim_table[$];

  function automatic longint unsigned div_half_up(longint unsigned num,
                                                  longint unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  // log2 in Q.30: mantissa kept with 31 fraction bits, refined by squaring
  function automatic longint unsigned log2_q30(longint unsigned v);
    longint unsigned t, y, f;
    int e;
    t = v; e = 0; f = 0;
    while (t > 1) begin
      t >>= 1;
      e++;
    end
    y = (e >= 31) ? (v >> (e - 31)) : (v << (31 - e));
    for (int i = 0; i < 30; i++) begin
      y = (y * y) >> 31;
      f <<= 1;
      if (y >= 64'h1_0000_0000) begin
        y >>= 1;
        f |= 1;
      end
    end
    return (longint'(e) << 30) | f;
  endfunction

  function automatic void write_shadow(logic [IDX_W-1:0] idx, logic [19:0] d);
    case (idx)
      CFG_SAMPLES: regs.samples     = d[CNT_W-1:0];
      CFG_SERIES:  regs.series      = d[OHM_W-1:0];
      CFG_NOMINAL: regs.nominal     = d[OHM_W-1:0];
      CFG_TEMP_C:  regs.temp_c      = d[TEMPC_W-1:0];
      CFG_BETA:    regs.beta        = d[BETA_W-1:0];
      CFG_TFIRST:  regs.therm_first = d[0];
      CFG_VCC:     regs.vcc         = d[MV_W-1:0];
      CFG_AREF:    regs.aref        = d[MV_W-1:0];
      default: ;
    endcase
  endfunction

  // Adds one sample; returns 1 with the reading when the count is reached.
  function automatic bit convert_sample(logic [SAMPLE_W-1:0] x, output tb_reading_t r);
    longint unsigned n, sum, full, num, den, avg, volt, res, ck, top, sub;
    longint unsigned la, lb, dmag, lnmag, q, inv0;
    longint signed t0, s, cc, cf;
    logic [1:0] st;
    bit ok, neg;
    n = regs.samples;
    num = 0; den = 1; res = 0; ck = 0; cc = 0; cf = 0; st = STATUS_OK;
    r = '0;
    if (n == 0) n = 1;
    if (n > MAX_SAMPLES) n = MAX_SAMPLES;
    acc_sum   = acc_sum + SUM_W'(x);
    acc_count = acc_count + CNT_W'(1);
    if (acc_count < n) return 0;
    sum = acc_sum;
    acc_sum = '0;
    acc_count = '0;
    full = ADC_MAX * n;
    avg  = div_half_up(sum * 256, n);
    volt = div_half_up(longint'(regs.aref) * 1000 * sum, full);
    if (volt > VOLT_TOP) volt = VOLT_TOP;
    if (regs.therm_first) begin
      ok = regs.aref != 0 && sum != 0 && full > sum && regs.series != 0;
      if (ok) begin
        num = longint'(regs.series) * (full - sum);
        den = sum;
      end
    end else begin
      top = longint'(regs.vcc) * full;
      sub = longint'(regs.aref) * sum;
      ok = top > sub && sub != 0 && regs.series != 0;
      if (ok) begin
        num = longint'(regs.aref) * longint'(regs.series) * sum;
        den = top - sub;
      end
    end
    if (!ok) begin
      st = STATUS_INVALID;
    end else begin
      res = div_half_up(num, den);
      if (res > RES_TOP) begin
        res = RES_TOP; num = RES_TOP; den = 1; st = STATUS_RES_SAT;
      end
      if (regs.beta == 0 || regs.nominal == 0) begin
        st = STATUS_INVALID;
      end else begin
        la = log2_q30(num);
        lb = log2_q30(den * longint'(regs.nominal));
        neg = lb > la;
        dmag = neg ? lb - la : la - lb;
        lnmag = (dmag * LN2_Q24) >> 24;
        q = (lnmag << 10) / regs.beta;
        t0 = 100 * longint'($signed(regs.temp_c)) + ABS_ZERO_CENTI;
        inv0 = div_half_up(64'd100 << 40, t0);
        s = neg ? longint'(inv0) - longint'(q) : longint'(inv0) + longint'(q);
        if (s <= 0) begin
          st = STATUS_INVALID;
        end else begin
          ck = div_half_up(64'd100 << 40, s);
          if (ck > TEMP_TOP) begin
            ck = TEMP_TOP;
            if (st == STATUS_OK) st = STATUS_TEMP_SAT;
          end
          cc = longint'(ck) - ABS_ZERO_CENTI;
          cf = longint'((9 * ck + 2) / 5) - F_OFFSET;
        end
      end
    end
    r.avg = avg[19:0]; r.volt = volt[22:0]; r.res = res[23:0];
    r.ck = ck[16:0]; r.cc = cc[17:0]; r.cf = cf[18:0]; r.st = st;
    return 1;
  endfunction

  // ---- sample side ----
  // in_valid is left high after a beat; it is only lowered by an idle
  // burst or a pause, so it never gets two assignments in one step.
  task automatic send_beat(logic [SAMPLE_W-1:0] x, bit fixed, tb_reading_t fixed_r);
    tb_reading_t r;
    in_valid   <= 1'b1;
    adc_sample <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (convert_sample(x, r)) pending_readings.push_back(fixed ? fixed_r : r);
  endtask

  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // hold the samples until every reading is out and the back end is empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (BACKEND_CYCLES) @(posedge clk);
  endtask

  // cfg_valid stays high across back-to-back writes; close_writes drops it
  task automatic reg_write(logic [IDX_W-1:0] idx, logic [19:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    write_shadow(idx, d);
  endtask

  task automatic close_writes();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random register set for one phase; a wild set throws every bit of the resistor,
  // temperature, Beta and voltage fields at the block, a tame one keeps to a realistic divider.
  task automatic random_regs(logic [7:0] n, bit wild);
    reg_write(CFG_SAMPLES, 20'(n));
    if (wild) begin
      reg_write(CFG_SERIES,  20'($urandom_range(0, 20'hFFFFF)));
      reg_write(CFG_NOMINAL, 20'($urandom_range(0, 20'hFFFFF)));
      reg_write(CFG_TEMP_C,  20'($urandom_range(0, 9'h1FF)));
      reg_write(CFG_BETA,    20'($urandom_range(0, 14'h3FFF)));
      reg_write(CFG_VCC,     20'($urandom_range(0, 13'h1FFF)));
      reg_write(CFG_AREF,    20'($urandom_range(0, 13'h1FFF)));
    end else begin
      reg_write(CFG_SERIES,  20'($urandom_range(1000, 100000)));
      reg_write(CFG_NOMINAL, 20'($urandom_range(1000, 100000)));
      reg_write(CFG_TEMP_C,  20'($signed(9'($urandom_range(0, 205)) - 9'sd55)));
      reg_write(CFG_BETA,    20'($urandom_range(2000, 5000)));
      reg_write(CFG_VCC,     20'($urandom_range(1000, 6000)));
      reg_write(CFG_AREF,    20'($urandom_range(1000, 6000)));
    end
    reg_write(CFG_TFIRST, 20'($urandom_range(0, 1)));
    close_writes();
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 12'hFFF;
      2:       return SAMPLE_W'($urandom_range(0, 15));
      default: return SAMPLE_W'($urandom_range(0, 12'hFFF));
    endcase
  endfunction

  function automatic stim_row_t reg_row(logic [IDX_W-1:0] idx, logic [19:0] d);
    stim_row_t row = '0;
    row.kind = ROW_REG; row.idx = idx; row.data = d;
    return row;
  endfunction

  function automatic stim_row_t sample_row(logic [SAMPLE_W-1:0] x);
    stim_row_t row = '0;
    row.kind = ROW_SAMPLE; row.data = 20'(x);
    return row;
  endfunction

  // divider rejected outright: resistance and every temperature field are zero
  function automatic stim_row_t rejected_row(logic [SAMPLE_W-1:0] x,
                                             logic [19:0] avg, logic [22:0] volt);
    stim_row_t row = '0;
    row.kind = ROW_SAMPLE_FIXED; row.data = 20'(x);
    row.reading.avg = avg; row.reading.volt = volt; row.reading.st = STATUS_INVALID;
    return row;
  endfunction

  // ---- readings side ----
  always begin
    if (hold_req) begin
      out_stall <= 1'b1;
      repeat (LONG_HOLD) @(posedge clk);
      hold_req = 0;
    end else if (quiet || $urandom_range(0, 1) == 0) begin
      out_stall <= 1'b0;
      repeat (quiet ? 1 : $urandom_range(1, 16)) @(posedge clk);
    end else begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    tb_reading_t r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        mismatches++;
        $display("%0t: reading beat with none expected, expected nothing, got avg %0h",
                 $realtime, avg_counts_q8);
      end else begin
        r = pending_readings.pop_front();
        check_field("avg_counts_q8",   r.avg,  avg_counts_q8);
        check_field("voltage_uv",      r.volt, voltage_uv);
        check_field("resistance_ohms", r.res,  resistance_ohms);
        check_field("temp_centi_k",    r.ck,   temp_centi_k);
        check_field("temp_centi_c",    r.cc,   $unsigned(temp_centi_c));
        check_field("temp_centi_f",    r.cf,   $unsigned(temp_centi_f));
        check_field("status",          r.st,   status);
      end
    end
  end

  initial begin
    #60ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [7:0] phase_n [14] = '{1, 2, 3, 255, 5, 0, 1, 7, 4, 2, 1, 16, 3, 1};
    bit writing;
    int beats;
    regs = '{samples: 10, series: 10000, nominal: 10000, temp_c: 25, beta: 3950,
             therm_first: 0, vcc: 3300, aref: 3300};
    acc_sum = '0;
    acc_count = '0;
    writing = 0;

    // Directed rows. Default count is 10: three samples go in, then the
    // count drops to 2 so the next sample closes the reading early.
    stim_table.push_back(sample_row(12'd0));
    stim_table.push_back(sample_row(12'hFFF));
    stim_table.push_back(sample_row(12'd17));
    stim_table.push_back(reg_row(CFG_SAMPLES, 20'd2));
    stim_table.push_back(sample_row(12'd100));
    // count of zero behaves as one
    stim_table.push_back(reg_row(CFG_SAMPLES, 20'd0));
    stim_table.push_back(rejected_row(12'd0, 20'd0, 23'd0));
    stim_table.push_back(rejected_row(12'hFFF, 20'd1048320, 23'd3300000));
    stim_table.push_back(sample_row(12'd2048));
    stim_table.push_back(reg_row(CFG_TFIRST, 20'd1));
    stim_table.push_back(rejected_row(12'hFFF, 20'd1048320, 23'd3300000));
    stim_table.push_back(rejected_row(12'd0, 20'd0, 23'd0));
    // huge series resistor: resistance clips at the top
    stim_table.push_back(reg_row(CFG_SERIES, 20'd1000000));
    stim_table.push_back(sample_row(12'd1));
    stim_table.push_back(reg_row(CFG_SERIES, 20'd10000));
    stim_table.push_back(reg_row(CFG_BETA, 20'd0));
    stim_table.push_back(sample_row(12'd2000));
    stim_table.push_back(reg_row(CFG_BETA, 20'd1));
    stim_table.push_back(reg_row(CFG_NOMINAL, 20'd0));
    stim_table.push_back(sample_row(12'd2000));
    stim_table.push_back(reg_row(CFG_NOMINAL, 20'd1000000));
    stim_table.push_back(reg_row(CFG_TEMP_C, 20'd150));
    stim_table.push_back(sample_row(12'd4000));
    stim_table.push_back(sample_row(12'd5));
    stim_table.push_back(reg_row(CFG_TEMP_C, 20'h1C9));
    stim_table.push_back(reg_row(CFG_VCC, 20'd6000));
    stim_table.push_back(reg_row(CFG_AREF, 20'd1));
    stim_table.push_back(reg_row(CFG_SPARE, 20'hFFFFF));
    stim_table.push_back(sample_row(12'd3000));
    stim_table.push_back(reg_row(CFG_TFIRST, 20'd0));
    stim_table.push_back(sample_row(12'd3000));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_REG) begin
        if (!writing) drain();
        writing = 1;
        reg_write(stim_table[i].idx, stim_table[i].data);
      end else begin
        if (writing) close_writes();
        writing = 0;
        send_beat(stim_table[i].data[SAMPLE_W-1:0],
                  stim_table[i].kind == ROW_SAMPLE_FIXED, stim_table[i].reading);
        maybe_idle();
      end
    end
    if (writing) close_writes();

    // Random phases, each with its own register set. The first phase starts with a
    // long receiver hold-off so the queue fills and the input stalls.
    foreach (phase_n[p]) begin
      drain();
      quiet = (p == 13);
      random_regs(phase_n[p], p % 4 == 3 || p == 5);
      if (p == 0) hold_req = 1;
      beats = (phase_n[p] == 255) ? 510 : 60;
      for (int k = 0; k < beats; k++) begin
        send_beat(pick_sample(), 0, '0);
        maybe_idle();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (BACKEND_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/ttc_pkg.sv
rtl/core/ttc_front.sv
rtl/core/ttc_queue.sv
rtl/core/ttc_divider.sv
rtl/core/ttc_back.sv
rtl/core/thermistor_temperature_converter.sv
sim/thermistor_temperature_converter_tb.sv
